### rtl/core/sensor_stream_frame_parser_core_defines.svh
`ifndef SENSOR_STREAM_FRAME_PARSER_CORE_DEFINES_SVH
`define SENSOR_STREAM_FRAME_PARSER_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SSFP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("ssfp assertion failed");

// next-cycle implication, disabled while in reset
`define SSFP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("ssfp assertion failed");

`endif

### rtl/core/ssfp_pkg.sv
package ssfp_pkg;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned KIND_W      = 2;
	localparam int unsigned OUT_DATA_W  = 24;
	localparam int unsigned APB_ADDR_W  = 3;
	localparam int unsigned APB_DATA_W  = 32;

	localparam logic [BYTE_W-1:0] HEADER_BYTE      = 8'd19;
	localparam logic [BYTE_W-1:0] STORE_LIMIT_RST  = 8'd255;
	localparam logic [BYTE_W-1:0] INDEX_NEVER      = 8'd255;

	localparam logic [KIND_W-1:0] KIND_NONE     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PAYLOAD  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SUM_GOOD = 2'd2;
	localparam logic [KIND_W-1:0] KIND_SUM_BAD  = 2'd3;

	// register word index, taken from paddr[2]
	localparam logic REG_STORE_LIMIT = 1'b0;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              within_limit;
		logic [BYTE_W-1:0] byte_index;
		logic [BYTE_W-1:0] payload_byte;
	} ssfp_result_t;

endpackage

### rtl/core/sensor_stream_frame_parser_core.sv
// channel   | dir | handshake                      | payload
// ----------+-----+--------------------------------+--------------------------------------
// s_axis    | in  | s_axis_tvalid / s_axis_tready  | tdata[7:0] rx_byte
// m_axis    | out | m_axis_tvalid / m_axis_tready  | tdata: payload_byte, byte_index,
//           |     |                                |   within_limit; tuser: kind
// apb       | in  | psel / penable / pready        | store_limit at byte address 0
//
// one item per cycle sustained while m_axis_tready holds; each item gives exactly one result item
// registered path: input register, then parse logic into the result register
// arst_n clears the parser to header hunt and store_limit to 255
// a stalled result holds; the input register takes items while it is empty or the
// result register is free or being emptied in the same cycle
module sensor_stream_frame_parser_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [ssfp_pkg::BYTE_W-1:0]          s_axis_tdata,  // [7:0] rx_byte
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// [7:0] payload_byte, [15:8] byte_index, [16] within_limit, [23:17] zero
	output logic [ssfp_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	output logic [ssfp_pkg::KIND_W-1:0]          m_axis_tuser,  // [1:0] kind
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [ssfp_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [ssfp_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [ssfp_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                 pready
);
	import ssfp_pkg::*;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_LEN  = 2'd1;
	localparam logic [1:0] PH_DATA = 2'd2;
	localparam logic [1:0] PH_SUM  = 2'd3;

	logic [BYTE_W-1:0] store_limit_q;
	logic [1:0]        phase_q;
	logic [BYTE_W-1:0] frame_len_q;
	logic [BYTE_W-1:0] seen_q;
	logic [BYTE_W-1:0] sum_q;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              valid_s2;
	ssfp_result_t      res_s2;

	logic              adv_s1;
	logic [1:0]        phase_d;
	logic [BYTE_W-1:0] frame_len_d;
	logic [BYTE_W-1:0] seen_d;
	logic [BYTE_W-1:0] sum_d;
	logic [BYTE_W-1:0] seen_inc;
	logic [BYTE_W-1:0] sum_add;
	ssfp_result_t      res_d;
	logic              cfg_wr;

	// apb
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_STORE_LIMIT)
		? {{(APB_DATA_W-BYTE_W){1'b0}}, store_limit_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_limit_q <= STORE_LIMIT_RST;
		end else if (cfg_wr && paddr[2] == REG_STORE_LIMIT) begin
			store_limit_q <= pwdata[BYTE_W-1:0];
		end
	end

	// handshake
	assign adv_s1        = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	// parse
	assign seen_inc = seen_q + 8'd1;
	assign sum_add  = sum_q + byte_s1;

	always_comb begin
		phase_d     = phase_q;
		frame_len_d = frame_len_q;
		seen_d      = seen_q;
		sum_d       = sum_q;
		res_d       = '0;
		res_d.kind  = KIND_NONE;
		unique case (phase_q)
			PH_IDLE: begin
				if (byte_s1 == HEADER_BYTE) begin
					phase_d = PH_LEN;
				end
			end
			PH_LEN: begin
				frame_len_d = byte_s1;
				sum_d       = byte_s1;
				seen_d      = '0;
				phase_d     = (byte_s1 == '0) ? PH_SUM : PH_DATA;
			end
			PH_DATA: begin
				sum_d              = sum_add;
				res_d.kind         = KIND_PAYLOAD;
				res_d.payload_byte = byte_s1;
				res_d.byte_index   = seen_q;
				res_d.within_limit = seen_q < store_limit_q;
				seen_d             = seen_inc;
				if (seen_inc >= frame_len_q) begin
					phase_d = PH_SUM;
				end
			end
			PH_SUM: begin
				sum_d      = sum_add;
				res_d.kind = (sum_add == '0) ? KIND_SUM_GOOD : KIND_SUM_BAD;
				phase_d    = PH_IDLE;
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			frame_len_q <= '0;
			seen_q      <= '0;
			sum_q       <= '0;
		end else if (adv_s1) begin
			phase_q     <= phase_d;
			frame_len_q <= frame_len_d;
			seen_q      <= seen_d;
			sum_q       <= sum_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_axis_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_d;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = res_s2.kind;
	assign m_axis_tdata  = {{(OUT_DATA_W-2*BYTE_W-1){1'b0}}, res_s2.within_limit,
		res_s2.byte_index, res_s2.payload_byte};

endmodule

### rtl/core/ssfp_checker.sv
`include "sensor_stream_frame_parser_core_defines.svh"

module ssfp_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [ssfp_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input logic [ssfp_pkg::KIND_W-1:0]      m_axis_tuser
);
	import ssfp_pkg::*;

	logic [BYTE_W-1:0] out_index;
	logic              is_payload;

	assign out_index  = m_axis_tdata[2*BYTE_W-1:BYTE_W];
	assign is_payload = m_axis_tuser == KIND_PAYLOAD;

	`SSFP_ASSERT_NXT(a_stall_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

	`SSFP_ASSERT_IMP(a_non_payload_zero, clk, arst_n, m_axis_tvalid && !is_payload,
		m_axis_tdata == '0)

	`SSFP_ASSERT_IMP(a_index_range, clk, arst_n, m_axis_tvalid && is_payload,
		out_index != INDEX_NEVER)

endmodule

bind sensor_stream_frame_parser_core ssfp_checker u_ssfp_checker (.*);

### tb/sensor_stream_frame_parser_core_test.sv
`timescale 1ns / 100ps

module sensor_stream_frame_parser_core_test;
	import ssfp_pkg::*;

	localparam logic [APB_ADDR_W-1:0] ADDR_STORE_LIMIT = 3'd0;
	localparam logic [APB_ADDR_W-1:0] ADDR_UNUSED      = 3'd4;
	localparam int STALL_LIMIT   = 2000;
	localparam int HOLD_CYCLES   = 300;
	localparam int PHASE_ITEMS   = 250;

	typedef enum logic [1:0] {PH_HUNT, PH_LENGTH, PH_PAYLOAD, PH_CHECKSUM} parse_phase_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [BYTE_W-1:0]     s_axis_tdata = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [KIND_W-1:0]     m_axis_tuser;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	// parser shadow state
	parse_phase_t      parse_phase = PH_HUNT;
	logic [BYTE_W-1:0] frame_len = '0;
	logic [BYTE_W-1:0] taken = '0;
	logic [BYTE_W-1:0] frame_sum = '0;
	logic [BYTE_W-1:0] limit_shadow = STORE_LIMIT_RST;

	ssfp_result_t deframed_q[$];
	int           mismatches = 0;
	int           items_sent = 0;
	int           stall_cycles = 0;
	bit           tx_idle = 1'b1;
	bit           rx_idle = 1'b1;
	int           rx_hold = 0;

	sensor_stream_frame_parser_core dut (.*);

	initial forever #6 clk = ~clk;

	function automatic ssfp_result_t deframe_byte(input logic [BYTE_W-1:0] b);
		ssfp_result_t r;
		r = '0;
		r.kind = KIND_NONE;
		case (parse_phase)
		PH_HUNT: begin
			if (b == HEADER_BYTE)
				parse_phase = PH_LENGTH;
		end
		PH_LENGTH: begin
			frame_len = b;
			frame_sum = b;
			taken = '0;
			parse_phase = (b == '0) ? PH_CHECKSUM : PH_PAYLOAD;
		end
		PH_PAYLOAD: begin
			frame_sum = frame_sum + b;
			r.kind = KIND_PAYLOAD;
			r.payload_byte = b;
			r.byte_index = taken;
			r.within_limit = (taken < limit_shadow);
			taken = taken + 8'd1;
			if (taken >= frame_len)
				parse_phase = PH_CHECKSUM;
		end
		default: begin
			frame_sum = frame_sum + b;
			r.kind = (frame_sum == '0) ? KIND_SUM_GOOD : KIND_SUM_BAD;
			parse_phase = PH_HUNT;
		end
		endcase
		return r;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// predict on input handshake, compare on output handshake
	always @(posedge clk) begin
		ssfp_result_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				deframed_q.push_back(deframe_byte(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				if (deframed_q.size() == 0) begin
					$display("%0t: unexpected item, expected none actual kind %0h data %0h",
						$time, m_axis_tuser, m_axis_tdata);
					mismatches++;
				end else begin
					want = deframed_q.pop_front();
					check_field("kind", {6'd0, want.kind}, {6'd0, m_axis_tuser});
					check_field("payload_byte", want.payload_byte, m_axis_tdata[7:0]);
					check_field("byte_index", want.byte_index, m_axis_tdata[15:8]);
					check_field("within_limit", {7'd0, want.within_limit},
						{7'd0, m_axis_tdata[16]});
					check_field("tdata pad", 8'd0, {1'b0, m_axis_tdata[23:17]});
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
				$display("** sensor_stream_frame_parser_core: FAILED **");
				$finish;
			end
		end
	end

	// receiver: random stalls, one long hold on request
	initial begin
		int n;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (rx_hold > 0) begin
				n = rx_hold;
				rx_hold = 0;
				m_axis_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end else if (rx_idle && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		if (tx_idle && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		@(posedge clk);
		while (!(s_axis_tvalid && s_axis_tready))
			@(posedge clk);
		items_sent++;
	endtask

	task automatic send_frame(input int len, input bit good);
		logic [BYTE_W-1:0] sum;
		logic [BYTE_W-1:0] b;
		sum = len[7:0];
		send_byte(HEADER_BYTE);
		send_byte(len[7:0]);
		repeat (len) begin
			b = 8'($urandom);
			sum = sum + b;
			send_byte(b);
		end
		b = -sum;
		if (!good)
			b = b ^ 8'($urandom_range(1, 255));
		send_byte(b);
	endtask

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (deframed_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [APB_DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (addr == ADDR_STORE_LIMIT)
			limit_shadow = data[7:0];
		@(posedge clk);
	endtask

	task automatic check_limit_readback;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_STORE_LIMIT;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		check_field("prdata[7:0]", limit_shadow, prdata[7:0]);
		if (prdata[31:8] !== '0) begin
			$display("%0t: prdata expected %0h actual %0h", $time,
				{24'd0, limit_shadow}, prdata);
			mismatches++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_store_limit(input logic [BYTE_W-1:0] value);
		drain();
		apb_write(ADDR_STORE_LIMIT, {24'($urandom), value});
		check_limit_readback();
	endtask

	task automatic test_registers;
		check_limit_readback();
		apb_write(ADDR_UNUSED, $urandom);
		check_limit_readback();
		set_store_limit(8'd2);
	endtask

	task automatic test_directed;
		// noise before any header
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'd18);
		send_byte(8'd20);
		// empty payload, good then bad checksum
		send_byte(HEADER_BYTE);
		send_byte(8'd0);
		send_byte(8'd0);
		send_byte(HEADER_BYTE);
		send_byte(8'd0);
		send_byte(8'd1);
		// header value inside a frame is data, index 2 crosses the limit
		send_byte(HEADER_BYTE);
		send_byte(8'd3);
		send_byte(HEADER_BYTE);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'd235);
		send_byte(HEADER_BYTE);
		send_byte(8'd1);
		send_byte(8'hAA);
		send_byte(8'h00);
		drain();
	endtask

	task automatic random_traffic(input int count);
		int stop;
		int r;
		int len;
		stop = items_sent + count;
		while (items_sent < stop) begin
			r = $urandom_range(0, 19);
			if (r < 2) begin
				send_byte(8'($urandom));
			end else if (r == 2) begin
				// truncated frame
				len = $urandom_range(2, 12);
				send_byte(HEADER_BYTE);
				send_byte(len[7:0]);
				repeat (len / 2) send_byte(8'($urandom));
			end else begin
				len = ($urandom_range(0, 29) == 0) ? $urandom_range(200, 255) :
					$urandom_range(0, 12);
				send_frame(len, $urandom_range(0, 3) != 0);
			end
		end
	endtask

	task automatic test_limit_sweep;
		logic [BYTE_W-1:0] limits[6];
		limits = '{8'd255, 8'd0, 8'd1, 8'd128, 8'd254, 8'd0};
		limits[5] = 8'($urandom);
		foreach (limits[i]) begin
			set_store_limit(limits[i]);
			random_traffic(PHASE_ITEMS);
		end
		drain();
	endtask

	task automatic test_backpressure;
		tx_idle = 1'b0;
		rx_hold = HOLD_CYCLES;
		random_traffic(60);
		drain();
		tx_idle = 1'b1;
	endtask

	task automatic test_full_rate;
		tx_idle = 1'b0;
		rx_idle = 1'b0;
		set_store_limit(8'($urandom_range(4, 10)));
		random_traffic(150);
		drain();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_registers();
		test_directed();
		test_limit_sweep();
		test_backpressure();
		test_full_rate();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && deframed_q.size() == 0) begin
			$display("** sensor_stream_frame_parser_core: PASSED **");
		end else begin
			$display("** sensor_stream_frame_parser_core: FAILED **");
		end
		$finish;
	end

endmodule
